// File: hdl/gjmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_pkg: shared types and constants of the Gauss-Jordan inverter
// Command and status bundles between controller and datapath, field widths.
// ----------------------------------------------------------------------------
package gjmi_pkg;

  // default sizing
  localparam int MAX_N_DEF     = 8;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 4;
  localparam int IDX_W       = 3;
  localparam int OUT_TDATA_W = 40;

  // ram write data source
  typedef enum logic [2:0] {
    WS_IN    = 3'd0,
    WS_ONE   = 3'd1,
    WS_ZERO  = 3'd2,
    WS_RDATA = 3'd3,
    WS_TEMP  = 3'd4,
    WS_DIFF  = 3'd5,
    WS_QUOT  = 3'd6
  } wsel_t;

  // controller to datapath commands
  typedef struct packed {
    logic  ram_we;
    wsel_t wsel;
    logic  temp_ld;
    logic  piv_ld;
    logic  div_start;
    logic  fac_ld;
    logic  prod_ld;
    logic  rowv_ld;
    logic  out_ld;
    logic  out_zero;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rdata_zero;
    logic div_busy;
  } stat_t;

endpackage

// File: hdl/gauss_jordan_matrix_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse: fixed-point Gauss-Jordan matrix inverter
// Loads an n x n matrix row-major, inverts it in a shared ram and streams
// out the inverse row-major with row, column, last and singular markers.
// ----------------------------------------------------------------------------
// loading: n*n elements are taken one item per cycle; the elimination then
//   runs on one ram read port and the bit-serial divider, and each result is
//   then held on the output until out_tready takes it
// throughput: one matrix at a time, no new item taken until the last result goes
// reset: synchronous active-low rst_n; size returns to 8, load count and
//   singular flag clear, ram contents are left as they are
module gauss_jordan_matrix_inverse #(
  parameter int MAX_N     = gjmi_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = gjmi_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gjmi_pkg::DATA_W-1:0]      in_tdata,   // element_value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gjmi_pkg::OUT_TDATA_W-1:0] out_tdata,  // inverse_value, row_index, column_index
  output logic                             out_tlast,  // last_element
  output logic                             out_tuser,  // singular
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gjmi_pkg::SIZE_W-1:0]      cfg_data    // matrix_size
);

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW = $clog2(2 * MAX_N);

  gjmi_pkg::cmd_t                    cmd;
  gjmi_pkg::stat_t                   stat;
  logic [IW-1:0]                     rd_row, wr_row;
  logic [CW-1:0]                     rd_col, wr_col;
  logic [gjmi_pkg::IDX_W-1:0]        out_row, out_col;
  logic signed [gjmi_pkg::DATA_W-1:0] out_value;

  gjmi_ctrl #(
    .MAX_N (MAX_N),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_last     (out_tlast),
    .out_singular (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .rd_row       (rd_row),
    .rd_col       (rd_col),
    .wr_row       (wr_row),
    .wr_col       (wr_col)
  );

  gjmi_dp #(
    .MAX_N     (MAX_N),
    .FRAC_BITS (FRAC_BITS),
    .IW        (IW),
    .CW        (CW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .wr_row    (wr_row),
    .wr_col    (wr_col),
    .in_value  ($signed(in_tdata)),
    .stat      (stat),
    .out_value (out_value)
  );

  // result payload, zero padded to whole bytes
  assign out_tdata = {2'b00, out_col, out_row, out_value};

endmodule

// File: hdl/gjmi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gjmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/gjmi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_div: iterative fixed-point divider
// Restoring division of (a << FRAC_BITS) by b, one quotient bit per cycle,
// truncated toward zero and saturated to 32 bits; zero divisor gives zero.
// ----------------------------------------------------------------------------
module gjmi_div #(
  parameter int FRAC_BITS = gjmi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gjmi_pkg::DATA_W-1:0] a,
  input  logic signed [gjmi_pkg::DATA_W-1:0] b,
  output logic                              busy,
  output logic signed [gjmi_pkg::DATA_W-1:0] q
);

  localparam int DW  = gjmi_pkg::DATA_W + FRAC_BITS;
  localparam int CNW = $clog2(DW + 1);
  localparam logic [DW-1:0] LIM_POS = DW'(64'h0000_0000_7FFF_FFFF);
  localparam logic [DW-1:0] LIM_NEG = DW'(64'h0000_0000_8000_0000);

  logic [DW-1:0]              dvd_r, dvd_nxt;
  logic [gjmi_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [gjmi_pkg::DATA_W-1:0] bmag_r, bmag_nxt;
  logic                       neg_r, neg_nxt;
  logic                       bz_r, bz_nxt;
  logic [CNW-1:0]             cnt_r, cnt_nxt;
  logic [gjmi_pkg::DATA_W-1:0] amag;
  logic [gjmi_pkg::DATA_W:0]   trial;

  assign amag  = a[gjmi_pkg::DATA_W-1] ? gjmi_pkg::DATA_W'(-a) : gjmi_pkg::DATA_W'(a);
  assign trial = {rem_r, dvd_r[DW-1]};
  assign busy  = (cnt_r != '0);

  // one quotient bit per cycle
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    bmag_nxt = bmag_r;
    neg_nxt  = neg_r;
    bz_nxt   = bz_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      dvd_nxt  = {amag, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      bmag_nxt = b[gjmi_pkg::DATA_W-1] ? gjmi_pkg::DATA_W'(-b) : gjmi_pkg::DATA_W'(b);
      neg_nxt  = a[gjmi_pkg::DATA_W-1] ^ b[gjmi_pkg::DATA_W-1];
      bz_nxt   = (b == '0);
      cnt_nxt  = CNW'(DW);
    end else if (busy) begin
      if (trial >= {1'b0, bmag_r}) begin
        rem_nxt = gjmi_pkg::DATA_W'(trial - {1'b0, bmag_r});
        dvd_nxt = {dvd_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[gjmi_pkg::DATA_W-1:0];
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNW'(1);
    end
  end

  // sign and saturation of the finished quotient
  always_comb begin
    if (bz_r) begin
      q = '0;
    end else if (neg_r) begin
      q = (dvd_r > LIM_NEG) ? 32'sh8000_0000 : -$signed(dvd_r[gjmi_pkg::DATA_W-1:0]);
    end else begin
      q = (dvd_r > LIM_POS) ? 32'sh7FFF_FFFF : $signed(dvd_r[gjmi_pkg::DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    bmag_r <= bmag_nxt;
    neg_r  <= neg_nxt;
    bz_r   <= bz_nxt;
  end

endmodule

// File: hdl/gjmi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_dp: datapath of the Gauss-Jordan inverter
// Augmented-matrix ram, multiply-subtract pipe, divider and operand registers.
// ----------------------------------------------------------------------------
module gjmi_dp #(
  parameter int MAX_N     = gjmi_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = gjmi_pkg::FRAC_BITS_DEF,
  parameter int IW        = (MAX_N > 1) ? $clog2(MAX_N) : 1,
  parameter int CW        = $clog2(2 * MAX_N)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gjmi_pkg::cmd_t                     cmd,
  input  logic [IW-1:0]                      rd_row,
  input  logic [CW-1:0]                      rd_col,
  input  logic [IW-1:0]                      wr_row,
  input  logic [CW-1:0]                      wr_col,
  input  logic signed [gjmi_pkg::DATA_W-1:0]  in_value,
  output gjmi_pkg::stat_t                    stat,
  output logic signed [gjmi_pkg::DATA_W-1:0]  out_value
);

  localparam int ROW_WORDS = 2 * MAX_N;
  localparam int DEPTH     = MAX_N * ROW_WORDS;
  localparam int AW        = $clog2(DEPTH);
  localparam logic signed [gjmi_pkg::DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic [AW-1:0]                      raddr, waddr;
  logic signed [gjmi_pkg::DATA_W-1:0] rdata, wdata;
  logic signed [gjmi_pkg::DATA_W-1:0] temp_r, pivot_r, factor_r, rowv_r, out_r;
  logic signed [63:0]                 prod_r;
  logic signed [63:0]                 prod_sh;
  logic signed [gjmi_pkg::DATA_W-1:0] prod_sat, diff_sat, quot;
  logic signed [gjmi_pkg::DATA_W:0]   diff;
  logic                               div_busy;

  // row-major addressing, rows of 2*MAX_N words
  assign raddr = AW'(rd_row) * AW'(ROW_WORDS) + AW'(rd_col);
  assign waddr = AW'(wr_row) * AW'(ROW_WORDS) + AW'(wr_col);

  gjmi_ram #(
    .WIDTH (gjmi_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  gjmi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .a     (rdata),
    .b     (pivot_r),
    .busy  (div_busy),
    .q     (quot)
  );

  // product scaled with floor rounding, saturated, then saturating subtract
  always_comb begin
    prod_sh = prod_r >>> FRAC_BITS;
    if (prod_sh > 64'sh0000_0000_7FFF_FFFF) begin
      prod_sat = 32'sh7FFF_FFFF;
    end else if (prod_sh < -64'sh0000_0000_8000_0000) begin
      prod_sat = 32'sh8000_0000;
    end else begin
      prod_sat = prod_sh[gjmi_pkg::DATA_W-1:0];
    end
    diff = {rowv_r[gjmi_pkg::DATA_W-1], rowv_r} - {prod_sat[gjmi_pkg::DATA_W-1], prod_sat};
    if (diff[gjmi_pkg::DATA_W] != diff[gjmi_pkg::DATA_W-1]) begin
      diff_sat = diff[gjmi_pkg::DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      diff_sat = diff[gjmi_pkg::DATA_W-1:0];
    end
  end

  // ram write data select
  always_comb begin
    case (cmd.wsel)
      gjmi_pkg::WS_IN:    wdata = in_value;
      gjmi_pkg::WS_ONE:   wdata = ONE;
      gjmi_pkg::WS_ZERO:  wdata = '0;
      gjmi_pkg::WS_RDATA: wdata = rdata;
      gjmi_pkg::WS_TEMP:  wdata = temp_r;
      gjmi_pkg::WS_DIFF:  wdata = diff_sat;
      gjmi_pkg::WS_QUOT:  wdata = quot;
      default:            wdata = '0;
    endcase
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (cmd.temp_ld) begin
      temp_r <= rdata;
    end
    if (cmd.piv_ld) begin
      pivot_r <= rdata;
    end
    if (cmd.fac_ld) begin
      factor_r <= quot;
    end
    if (cmd.prod_ld) begin
      prod_r <= rdata * factor_r;
    end
    if (cmd.rowv_ld) begin
      rowv_r <= rdata;
    end
    if (cmd.out_ld) begin
      out_r <= cmd.out_zero ? '0 : rdata;
    end
  end

  assign stat.rdata_zero = (rdata == '0);
  assign stat.div_busy   = div_busy;
  assign out_value       = out_r;

endmodule

// File: hdl/gjmi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_ctrl: controller of the Gauss-Jordan inverter
// Load counting, identity fill, pivot search and swap, elimination sweeps,
// pivot-row scaling and result readout, plus the matrix size register.
// ----------------------------------------------------------------------------
module gjmi_ctrl #(
  parameter int MAX_N = gjmi_pkg::MAX_N_DEF,
  parameter int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1,
  parameter int CW    = $clog2(2 * MAX_N)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gjmi_pkg::IDX_W-1:0]  out_row,
  output logic [gjmi_pkg::IDX_W-1:0]  out_col,
  output logic                        out_last,
  output logic                        out_singular,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gjmi_pkg::SIZE_W-1:0] cfg_data,
  output gjmi_pkg::cmd_t              cmd,
  input  gjmi_pkg::stat_t             stat,
  output logic [IW-1:0]               rd_row,
  output logic [CW-1:0]               rd_col,
  output logic [IW-1:0]               wr_row,
  output logic [CW-1:0]               wr_col
);

  localparam int NW = $clog2(MAX_N + 1);

  typedef enum logic [23:0] {
    S_LOAD      = 24'h000001,
    S_IDENT     = 24'h000002,
    S_PIV_RD    = 24'h000004,
    S_PIV_CHK   = 24'h000008,
    S_SRCH_RD   = 24'h000010,
    S_SRCH_CHK  = 24'h000020,
    S_SWP_RDA   = 24'h000040,
    S_SWP_RDB   = 24'h000080,
    S_SWP_WA    = 24'h000100,
    S_SWP_WB    = 24'h000200,
    S_ROW_START = 24'h000400,
    S_FAC_DIV   = 24'h000800,
    S_FAC_WAIT  = 24'h001000,
    S_EL_RDK    = 24'h002000,
    S_EL_RDR    = 24'h004000,
    S_EL_MUL    = 24'h008000,
    S_EL_WR     = 24'h010000,
    S_NRM_RD    = 24'h020000,
    S_NRM_DIV   = 24'h040000,
    S_NRM_WAIT  = 24'h080000,
    S_SING      = 24'h100000,
    S_OUT_RD    = 24'h200000,
    S_OUT_LD    = 24'h400000,
    S_OUT_HOLD  = 24'h800000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [gjmi_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [IW-1:0]               ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic [IW-1:0]               k_r, k_nxt, r_r, r_nxt, f_r, f_nxt;
  logic [CW-1:0]               c_r, c_nxt;
  logic                        sing_r, sing_nxt;
  logic [NW-1:0]               n_eff, nm1;
  logic [NW:0]                 wm1;
  logic                        r_last, k_last, c_last_n, c_last_w;
  logic                        ld_row_last, ld_col_last;

  // effective size, clamped to 1..MAX_N
  always_comb begin
    if (size_r == '0) begin
      n_eff = NW'(1);
    end else if (size_r > gjmi_pkg::SIZE_W'(MAX_N)) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(size_r);
    end
  end

  assign nm1         = n_eff - NW'(1);
  assign wm1         = {n_eff, 1'b0} - (NW + 1)'(1);
  assign r_last      = (NW'(r_r) == nm1);
  assign k_last      = (NW'(k_r) == nm1);
  assign c_last_n    = (NW'(c_r) == nm1);
  assign c_last_w    = ((NW + 1)'(c_r) == wm1);
  assign ld_row_last = (NW'(ld_row_r) == nm1);
  assign ld_col_last = (NW'(ld_col_r) == nm1);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    size_nxt   = size_r;
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    k_nxt      = k_r;
    r_nxt      = r_r;
    f_nxt      = f_r;
    c_nxt      = c_r;
    sing_nxt   = sing_r;
    cmd        = '0;
    cmd.wsel   = gjmi_pkg::WS_IN;
    rd_row     = '0;
    rd_col     = '0;
    wr_row     = '0;
    wr_col     = '0;
    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          cmd.ram_we = 1'b1;
          wr_row     = ld_row_r;
          wr_col     = CW'(ld_col_r);
          if (ld_row_last && ld_col_last) begin
            ld_row_nxt = '0;
            ld_col_nxt = '0;
            sing_nxt   = 1'b0;
            r_nxt      = '0;
            c_nxt      = '0;
            state_nxt  = S_IDENT;
          end else if (ld_col_last) begin
            ld_col_nxt = '0;
            ld_row_nxt = ld_row_r + IW'(1);
          end else begin
            ld_col_nxt = ld_col_r + IW'(1);
          end
        end
      end
      S_IDENT: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = (CW'(r_r) == c_r) ? gjmi_pkg::WS_ONE : gjmi_pkg::WS_ZERO;
        wr_row     = r_r;
        wr_col     = CW'(n_eff) + c_r;
        if (c_last_n) begin
          c_nxt = '0;
          if (r_last) begin
            k_nxt     = '0;
            state_nxt = S_PIV_RD;
          end else begin
            r_nxt = r_r + IW'(1);
          end
        end else begin
          c_nxt = c_r + CW'(1);
        end
      end
      S_PIV_RD: begin
        rd_row    = k_r;
        rd_col    = CW'(k_r);
        state_nxt = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        if (!stat.rdata_zero) begin
          cmd.piv_ld = 1'b1;
          r_nxt      = '0;
          state_nxt  = S_ROW_START;
        end else if (k_last) begin
          state_nxt = S_SING;
        end else begin
          r_nxt     = k_r + IW'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        rd_row    = r_r;
        rd_col    = CW'(k_r);
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (!stat.rdata_zero) begin
          f_nxt     = r_r;
          c_nxt     = '0;
          state_nxt = S_SWP_RDA;
        end else if (r_last) begin
          state_nxt = S_SING;
        end else begin
          r_nxt     = r_r + IW'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_SWP_RDA: begin
        rd_row    = k_r;
        rd_col    = c_r;
        state_nxt = S_SWP_RDB;
      end
      S_SWP_RDB: begin
        rd_row      = f_r;
        rd_col      = c_r;
        cmd.temp_ld = 1'b1;
        state_nxt   = S_SWP_WA;
      end
      S_SWP_WA: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = gjmi_pkg::WS_RDATA;
        wr_row     = k_r;
        wr_col     = c_r;
        state_nxt  = S_SWP_WB;
      end
      S_SWP_WB: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = gjmi_pkg::WS_TEMP;
        wr_row     = f_r;
        wr_col     = c_r;
        if (c_last_w) begin
          state_nxt = S_PIV_RD;
        end else begin
          c_nxt     = c_r + CW'(1);
          state_nxt = S_SWP_RDA;
        end
      end
      S_ROW_START: begin
        if (r_r == k_r) begin
          if (r_last) begin
            c_nxt     = '0;
            state_nxt = S_NRM_RD;
          end else begin
            r_nxt = r_r + IW'(1);
          end
        end else begin
          rd_row    = r_r;
          rd_col    = CW'(k_r);
          state_nxt = S_FAC_DIV;
        end
      end
      S_FAC_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_FAC_WAIT;
      end
      S_FAC_WAIT: begin
        if (!stat.div_busy) begin
          cmd.fac_ld = 1'b1;
          c_nxt      = '0;
          state_nxt  = S_EL_RDK;
        end
      end
      S_EL_RDK: begin
        rd_row    = k_r;
        rd_col    = c_r;
        state_nxt = S_EL_RDR;
      end
      S_EL_RDR: begin
        rd_row      = r_r;
        rd_col      = c_r;
        cmd.prod_ld = 1'b1;
        state_nxt   = S_EL_MUL;
      end
      S_EL_MUL: begin
        cmd.rowv_ld = 1'b1;
        state_nxt   = S_EL_WR;
      end
      S_EL_WR: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = gjmi_pkg::WS_DIFF;
        wr_row     = r_r;
        wr_col     = c_r;
        if (c_last_w) begin
          c_nxt = '0;
          if (r_last) begin
            state_nxt = S_NRM_RD;
          end else begin
            r_nxt     = r_r + IW'(1);
            state_nxt = S_ROW_START;
          end
        end else begin
          c_nxt     = c_r + CW'(1);
          state_nxt = S_EL_RDK;
        end
      end
      S_NRM_RD: begin
        rd_row    = k_r;
        rd_col    = c_r;
        state_nxt = S_NRM_DIV;
      end
      S_NRM_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_NRM_WAIT;
      end
      S_NRM_WAIT: begin
        if (!stat.div_busy) begin
          cmd.ram_we = 1'b1;
          cmd.wsel   = gjmi_pkg::WS_QUOT;
          wr_row     = k_r;
          wr_col     = c_r;
          if (c_last_w) begin
            if (k_last) begin
              r_nxt     = '0;
              c_nxt     = '0;
              state_nxt = S_OUT_RD;
            end else begin
              k_nxt     = k_r + IW'(1);
              state_nxt = S_PIV_RD;
            end
          end else begin
            c_nxt     = c_r + CW'(1);
            state_nxt = S_NRM_RD;
          end
        end
      end
      S_SING: begin
        sing_nxt  = 1'b1;
        r_nxt     = '0;
        c_nxt     = '0;
        state_nxt = S_OUT_RD;
      end
      S_OUT_RD: begin
        rd_row    = r_r;
        rd_col    = CW'(n_eff) + c_r;
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_ld   = 1'b1;
        cmd.out_zero = sing_r;
        state_nxt    = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (out_tready) begin
          if (r_last && c_last_n) begin
            state_nxt = S_LOAD;
          end else begin
            if (c_last_n) begin
              c_nxt = '0;
              r_nxt = r_r + IW'(1);
            end else begin
              c_nxt = c_r + CW'(1);
            end
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    // size write drops a partly loaded matrix
    if (cfg_valid) begin
      size_nxt   = cfg_data;
      ld_row_nxt = '0;
      ld_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      size_r   <= gjmi_pkg::SIZE_W'(8);
      ld_row_r <= '0;
      ld_col_r <= '0;
      k_r      <= '0;
      r_r      <= '0;
      f_r      <= '0;
      c_r      <= '0;
      sing_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      size_r   <= size_nxt;
      ld_row_r <= ld_row_nxt;
      ld_col_r <= ld_col_nxt;
      k_r      <= k_nxt;
      r_r      <= r_nxt;
      f_r      <= f_nxt;
      c_r      <= c_nxt;
      sing_r   <= sing_nxt;
    end
  end

  // handshake and result markers
  assign in_tready    = (state_r == S_LOAD);
  assign out_tvalid   = (state_r == S_OUT_HOLD);
  assign cfg_ready    = 1'b1;
  assign out_row      = gjmi_pkg::IDX_W'(r_r);
  assign out_col      = gjmi_pkg::IDX_W'(c_r);
  assign out_last     = r_last && c_last_n;
  assign out_singular = sing_r;

endmodule

// File: hdl/gjmi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_port_sva: port-level checks of the Gauss-Jordan inverter
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module gjmi_port_sva (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [gjmi_pkg::DATA_W-1:0]      in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gjmi_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic                             out_tuser,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [gjmi_pkg::SIZE_W-1:0]      cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // loading and readout never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during readout");

  // singular results carry a zero value
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:0] == 32'd0)
    else $error("singular result with nonzero value");

  // after the last result the block loads again
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("not ready for a new matrix after last result");

  // accepted items and size writes carry known data
  a_inputs_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) || (cfg_valid && cfg_ready) |->
      !$isunknown({in_tdata, cfg_data}))
    else $error("unknown data on an accepted item or size write");

endmodule

bind gauss_jordan_matrix_inverse gjmi_port_sva u_gjmi_port_sva (.*);
